// ===== sv/hrsl_pkg.sv =====
// shared types and constants for the high-voltage ramp slew limiter
package hrsl_pkg;

	// channel count and level width
	localparam int NCH      = 4;
	localparam int CH_W     = 2;
	localparam int LVL_W    = 16;
	localparam int HOLD_W   = 4;
	localparam int CFG_IDX_W = 3;

	// default tick period and the per-second scale
	localparam int TICK_MS_DEF = 20;
	localparam int MS_PER_S    = 1000;

	// the increment is in counts per second, scaled by four per tick
	localparam int STEP_SCALE = 4;

	// operation codes of an input item
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INC_CH0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INC_CH1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INC_CH2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INC_CH3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd4;

	// tick sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_UPD,
		ST_OUT
	} ramp_state_t;

endpackage

// ===== sv/hv_ramp_slew_limiter.sv =====
// top level of the four-channel high-voltage ramp slew limiter
//
// Usage: items enter on in_valid/in_stall. A load item (operation 1) sets the
// target of one channel and restarts its ramp; it gives no result. A tick
// item (operation 0) visits each ramping channel in order 0..3 and gives one
// result per channel on out_valid/out_stall, the last one flagged by
// last_result. A tick with no ramping channel gives no result. Each channel
// makes two passes through one shared multiplier (increment times tick
// scale, then times the reciprocal of 1000), then a correction step, an
// update step and a step presenting the result until the receiver takes it.
// A channel in delayed settle skips the multiplier passes and the correction.
// While a tick is handled, in_stall stays high until the last result is
// transferred.
// While the receiver stalls, the result register holds and the sequencer
// waits. Reset clears all levels and targets, marks every channel settled,
// clears the increments and the hold mask. Configuration writes are always
// taken (cfg_ready is high) and must be made while the block is idle.
module hv_ramp_slew_limiter #(
	parameter int TICK_MS = hrsl_pkg::TICK_MS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [hrsl_pkg::CH_W-1:0]      channel,
	input  logic [hrsl_pkg::LVL_W-1:0]     target_value,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hrsl_pkg::CH_W-1:0]      channel_out,
	output logic [hrsl_pkg::LVL_W-1:0]     dac_value,
	output logic                           dac_written,
	output logic                           settled,
	output logic                           last_result,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hrsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hrsl_pkg::LVL_W-1:0]     cfg_data
);

	// step arithmetic widths, derived from the level width and the tick period
	localparam int K_VAL = hrsl_pkg::STEP_SCALE * TICK_MS;
	localparam int KW    = $clog2(K_VAL + 1);
	localparam int PW    = hrsl_pkg::LVL_W + KW;
	localparam int SH    = PW + 10;
	localparam int MW    = SH - 9;
	localparam int PRW   = PW + MW;
	localparam int QW    = PRW - SH;
	localparam int CW    = hrsl_pkg::LVL_W + QW;
	localparam logic [MW-1:0] RECIP =
		MW'((64'd1 << SH) / 64'(hrsl_pkg::MS_PER_S));
	localparam logic [MW-1:0] K_OP = MW'(K_VAL);
	localparam logic [PW-1:0] DIVISOR = PW'(hrsl_pkg::MS_PER_S);

	localparam int NCH       = hrsl_pkg::NCH;
	localparam int CH_W      = hrsl_pkg::CH_W;
	localparam int LVL_W     = hrsl_pkg::LVL_W;
	localparam int CFG_IDX_W = hrsl_pkg::CFG_IDX_W;

	// configuration and channel state
	logic [LVL_W-1:0] inc_q     [NCH];
	logic [NCH-1:0]   hold_q;
	logic [LVL_W-1:0] cur_q     [NCH];
	logic [LVL_W-1:0] tgt_q     [NCH];
	logic [NCH-1:0]   settled_q;
	logic [NCH-1:0]   pend_q;

	// sequencer
	hrsl_pkg::ramp_state_t state_q, state_d;
	logic [NCH-1:0]  mask_q;
	logic [CH_W-1:0] ch_q;

	// shared multiplier and step datapath
	logic [PW-1:0]  mul_a;
	logic [MW-1:0]  mul_b;
	logic [PRW-1:0] prod_q;
	logic [PW-1:0]  p_q;
	logic [QW-1:0]  step_q;

	// result register
	logic             out_valid_q;
	logic [CH_W-1:0]  ch_out_q;
	logic [LVL_W-1:0] dac_q;
	logic             wr_q;
	logic             st_q;
	logic             last_q;

	logic in_acc;
	logic out_acc;
	logic tick_acc;
	logic load_acc;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign tick_acc = in_acc && (operation == hrsl_pkg::OP_TICK);
	assign load_acc = in_acc && (operation == hrsl_pkg::OP_LOAD);

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign channel_out = ch_out_q;
	assign dac_value   = dac_q;
	assign dac_written = wr_q;
	assign settled     = st_q;
	assign last_result = last_q;

	// lowest ramping channel of a mask
	function automatic logic [CH_W-1:0] first_ch(input logic [NCH-1:0] m);
		logic [CH_W-1:0] r;
		r = '0;
		for (int i = NCH - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = CH_W'(i);
			end
		end
		return r;
	endfunction

	// remaining channels after the one being handled
	logic [NCH-1:0] mask_rest;
	logic [NCH-1:0] tick_mask;
	always_comb begin
		mask_rest = mask_q;
		mask_rest[ch_q] = 1'b0;
		tick_mask = ~settled_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hrsl_pkg::ST_IDLE: begin
				if (tick_acc && (tick_mask != '0)) begin
					state_d = pend_q[first_ch(tick_mask)] ? hrsl_pkg::ST_UPD
					                                      : hrsl_pkg::ST_MUL1;
				end
			end
			hrsl_pkg::ST_MUL1: state_d = hrsl_pkg::ST_MUL2;
			hrsl_pkg::ST_MUL2: state_d = hrsl_pkg::ST_DIV;
			hrsl_pkg::ST_DIV:  state_d = hrsl_pkg::ST_UPD;
			hrsl_pkg::ST_UPD:  state_d = hrsl_pkg::ST_OUT;
			hrsl_pkg::ST_OUT: begin
				if (out_acc) begin
					if (mask_rest == '0) begin
						state_d = hrsl_pkg::ST_IDLE;
					end else if (pend_q[first_ch(mask_rest)]) begin
						state_d = hrsl_pkg::ST_UPD;
					end else begin
						state_d = hrsl_pkg::ST_MUL1;
					end
				end
			end
			default: state_d = hrsl_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: input stall and multiplier operands
	always_comb begin
		in_stall = 1'b1;
		mul_a    = PW'(inc_q[ch_q]);
		mul_b    = K_OP;
		case (state_q)
			hrsl_pkg::ST_IDLE: in_stall = 1'b0;
			hrsl_pkg::ST_MUL2: begin
				mul_a = prod_q[PW-1:0];
				mul_b = RECIP;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// state and channel pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrsl_pkg::ST_IDLE;
			mask_q  <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hrsl_pkg::ST_IDLE && tick_acc) begin
				mask_q <= tick_mask;
				ch_q   <= first_ch(tick_mask);
			end else if (state_q == hrsl_pkg::ST_OUT && out_acc) begin
				mask_q <= mask_rest;
				ch_q   <= first_ch(mask_rest);
			end
		end
	end

	// shared multiplier, then quotient by 1000 with one correction
	logic [QW-1:0] q0;
	logic [PW-1:0] rem;
	always_comb begin
		q0  = prod_q[PRW-1:SH];
		rem = p_q - PW'(q0 * DIVISOR);
	end

	always_ff @(posedge clk) begin
		if (state_q == hrsl_pkg::ST_MUL1 || state_q == hrsl_pkg::ST_MUL2) begin
			prod_q <= PRW'(mul_a) * PRW'(mul_b);
		end
		if (state_q == hrsl_pkg::ST_MUL2) begin
			p_q <= prod_q[PW-1:0];
		end
		if (state_q == hrsl_pkg::ST_DIV) begin
			step_q <= (rem >= DIVISOR) ? q0 + QW'(1) : q0;
		end
	end

	// gap against step for the channel being handled
	logic [LVL_W-1:0] cur_c;
	logic [LVL_W-1:0] tgt_c;
	logic [LVL_W-1:0] gap;
	logic [LVL_W-1:0] step_lvl;
	logic             snap;
	logic [LVL_W-1:0] moved;
	always_comb begin
		cur_c    = cur_q[ch_q];
		tgt_c    = tgt_q[ch_q];
		gap      = (cur_c < tgt_c) ? (tgt_c - cur_c) : (cur_c - tgt_c);
		step_lvl = LVL_W'(step_q);
		snap     = CW'(gap) <= CW'(step_q);
		moved    = (cur_c < tgt_c) ? (cur_c + step_lvl) : (cur_c - step_lvl);
	end

	// configuration registers and per-channel ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				inc_q[i] <= '0;
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
			end
			hold_q    <= '0;
			settled_q <= '1;
			pend_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < CFG_IDX_W'(NCH)) begin
					inc_q[cfg_index[CH_W-1:0]] <= cfg_data;
				end else if (cfg_index == hrsl_pkg::CFG_HOLD) begin
					hold_q <= cfg_data[hrsl_pkg::HOLD_W-1:0];
				end
			end
			if (state_q == hrsl_pkg::ST_IDLE && load_acc) begin
				tgt_q[channel]     <= target_value;
				settled_q[channel] <= 1'b0;
				pend_q[channel]    <= 1'b0;
			end
			if (state_q == hrsl_pkg::ST_UPD) begin
				if (pend_q[ch_q]) begin
					tgt_q[ch_q]     <= cur_c;
					settled_q[ch_q] <= 1'b1;
					pend_q[ch_q]    <= 1'b0;
				end else if (snap) begin
					cur_q[ch_q] <= tgt_c;
					if (hold_q[ch_q]) begin
						pend_q[ch_q] <= 1'b1;
					end else begin
						settled_q[ch_q] <= 1'b1;
					end
				end else begin
					cur_q[ch_q] <= moved;
				end
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == hrsl_pkg::ST_UPD) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == hrsl_pkg::ST_UPD) begin
			ch_out_q <= ch_q;
			last_q   <= (mask_rest == '0);
			if (pend_q[ch_q]) begin
				dac_q <= cur_c;
				wr_q  <= 1'b0;
				st_q  <= 1'b1;
			end else if (snap) begin
				dac_q <= tgt_c;
				wr_q  <= 1'b1;
				st_q  <= !hold_q[ch_q];
			end else begin
				dac_q <= moved;
				wr_q  <= 1'b1;
				st_q  <= 1'b0;
			end
		end
	end

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the four-channel high-voltage ramp slew limiter
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH       = hrsl_pkg::NCH;
	localparam int CH_W      = hrsl_pkg::CH_W;
	localparam int LVL_W     = hrsl_pkg::LVL_W;
	localparam int HOLD_W    = hrsl_pkg::HOLD_W;
	localparam int CFG_IDX_W = hrsl_pkg::CFG_IDX_W;

	localparam int TICK_PERIOD_MS = hrsl_pkg::TICK_MS_DEF;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int IDLE_CYCLES    = 40;
	localparam int ITEMS_PER_MODE = 75;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

	// one dac write as seen on the result port
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [LVL_W-1:0] lvl;
		logic             wr;
		logic             st;
		logic             last;
	} dac_result_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// one row of the directed table
	typedef struct {
		row_kind_t              kind;
		logic                   op;
		logic [CH_W-1:0]        ch;
		logic [CFG_IDX_W-1:0]   idx;
		logic [LVL_W-1:0]       val;
		bit                     typed;
		bit                     has_res;
		dac_result_t            res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 operation = hrsl_pkg::OP_TICK;
	logic [CH_W-1:0]      channel = '0;
	logic [LVL_W-1:0]     target_value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CH_W-1:0]      channel_out;
	logic [LVL_W-1:0]     dac_value;
	logic                 dac_written;
	logic                 settled;
	logic                 last_result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LVL_W-1:0]     cfg_data = '0;

	int err_cnt = 0;
	int cycle_cnt = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	// predicted channel state and register copy
	logic [LVL_W-1:0]  cur_lvl [NCH];
	logic [LVL_W-1:0]  tgt_lvl [NCH];
	logic [LVL_W-1:0]  ramp_inc [NCH];
	logic              is_settled [NCH];
	logic              settle_due [NCH];
	logic [HOLD_W-1:0] hold_bits;

	dac_result_t dac_writes_due[$];
	dir_row_t    dir_rows[$];

	hv_ramp_slew_limiter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.channel      (channel),
		.target_value (target_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel_out  (channel_out),
		.dac_value    (dac_value),
		.dac_written  (dac_written),
		.settled      (settled),
		.last_result  (last_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[hv_ramp_slew_limiter] ERROR");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic int unsigned slew_step(input int c);
		return (ramp_inc[c] * hrsl_pkg::STEP_SCALE * TICK_PERIOD_MS) / hrsl_pkg::MS_PER_S;
	endfunction

	// expected dac writes for one item, state updated in place
	task automatic advance_ramps(input logic op, input logic [CH_W-1:0] ch,
		input logic [LVL_W-1:0] val);
		int          n_live;
		int          k;
		int unsigned gap;
		int unsigned stp;
		dac_result_t r;
		if (op == hrsl_pkg::OP_LOAD) begin
			tgt_lvl[ch] = val;
			is_settled[ch] = 1'b0;
			settle_due[ch] = 1'b0;
		end else begin
			n_live = 0;
			k = 0;
			for (int c = 0; c < NCH; c++)
				if (!is_settled[c])
					n_live++;
			for (int c = 0; c < NCH; c++) begin
				if (!is_settled[c]) begin
					r.ch = CH_W'(c);
					r.last = (k == n_live - 1);
					k++;
					if (settle_due[c]) begin
						// delayed settle: target follows level, no dac write
						tgt_lvl[c] = cur_lvl[c];
						is_settled[c] = 1'b1;
						settle_due[c] = 1'b0;
						r.lvl = cur_lvl[c];
						r.wr = 1'b0;
						r.st = 1'b1;
					end else begin
						gap = (cur_lvl[c] < tgt_lvl[c]) ? tgt_lvl[c] - cur_lvl[c]
							: cur_lvl[c] - tgt_lvl[c];
						stp = slew_step(c);
						r.wr = 1'b1;
						if (gap <= stp) begin
							// snap to target, settle now or on the next tick
							cur_lvl[c] = tgt_lvl[c];
							r.lvl = tgt_lvl[c];
							if (hold_bits[c]) begin
								settle_due[c] = 1'b1;
								r.st = 1'b0;
							end else begin
								is_settled[c] = 1'b1;
								r.st = 1'b1;
							end
						end else begin
							if (cur_lvl[c] < tgt_lvl[c])
								cur_lvl[c] = cur_lvl[c] + LVL_W'(stp);
							else
								cur_lvl[c] = cur_lvl[c] - LVL_W'(stp);
							r.lvl = cur_lvl[c];
							r.st = 1'b0;
						end
					end
					dac_writes_due.push_back(r);
				end
			end
		end
	endtask

	// compare each result transfer with the oldest expectation
	task automatic check_dac_write();
		dac_result_t want;
		if (dac_writes_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result ch %0d level %h",
				channel_out, dac_value));
		end else begin
			want = dac_writes_due.pop_front();
			if (channel_out !== want.ch)
				report_mismatch($sformatf("channel_out %0d, want %0d", channel_out, want.ch));
			if (dac_value !== want.lvl)
				report_mismatch($sformatf("ch %0d dac_value %h, want %h",
					want.ch, dac_value, want.lvl));
			if (dac_written !== want.wr)
				report_mismatch($sformatf("ch %0d dac_written %b, want %b",
					want.ch, dac_written, want.wr));
			if (settled !== want.st)
				report_mismatch($sformatf("ch %0d settled %b, want %b",
					want.ch, settled, want.st));
			if (last_result !== want.last)
				report_mismatch($sformatf("ch %0d last_result %b, want %b",
					want.ch, last_result, want.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_dac_write();
	end

	// idle for a random number of cycles, then present one item until its transfer
	task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
		input logic [LVL_W-1:0] val);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		channel <= ch;
		target_value <= val;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (dac_writes_due.size() != 0);
	endtask

	// all results in, then let a tick with no result finish too
	task automatic drain();
		wait_results();
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < CFG_IDX_W'(NCH))
			ramp_inc[idx[CH_W-1:0]] = data;
		else if (idx == hrsl_pkg::CFG_HOLD)
			hold_bits = data[HOLD_W-1:0];
	endtask

	task automatic program_regs(input logic [LVL_W-1:0] i0, input logic [LVL_W-1:0] i1,
		input logic [LVL_W-1:0] i2, input logic [LVL_W-1:0] i3,
		input logic [HOLD_W-1:0] h);
		drain();
		write_reg(hrsl_pkg::CFG_INC_CH0, i0);
		write_reg(hrsl_pkg::CFG_INC_CH1, i1);
		write_reg(hrsl_pkg::CFG_INC_CH2, i2);
		write_reg(hrsl_pkg::CFG_INC_CH3, i3);
		write_reg(hrsl_pkg::CFG_HOLD, LVL_W'(h));
		// unmapped index, must be ignored
		write_reg(CFG_IDX_W'($urandom_range(hrsl_pkg::CFG_HOLD + 1, CFG_IDX_TOP)),
			LVL_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic dac_result_t dac_res(input logic [CH_W-1:0] ch,
		input logic [LVL_W-1:0] lvl, input logic wr, input logic st, input logic last);
		dac_result_t r;
		r.ch = ch;
		r.lvl = lvl;
		r.wr = wr;
		r.st = st;
		r.last = last;
		return r;
	endfunction

	function automatic dir_row_t item_row(input logic op, input logic [CH_W-1:0] ch,
		input logic [LVL_W-1:0] val);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.op = op;
		row.ch = ch;
		row.idx = '0;
		row.val = val;
		row.typed = 1'b0;
		row.has_res = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic dir_row_t typed_row(input logic op, input logic [CH_W-1:0] ch,
		input logic [LVL_W-1:0] val, input bit has_res, input dac_result_t res);
		dir_row_t row;
		row = item_row(op, ch, val);
		row.typed = 1'b1;
		row.has_res = has_res;
		row.res = res;
		return row;
	endfunction

	function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [LVL_W-1:0] data);
		dir_row_t row;
		row = item_row(hrsl_pkg::OP_TICK, '0, data);
		row.kind = ROW_REG;
		row.idx = idx;
		return row;
	endfunction

	initial begin
		dir_row_t         row;
		bit               in_cfg;
		int               n_before;
		int unsigned      stp;
		logic             op;
		logic [CH_W-1:0]  ch;
		logic [LVL_W-1:0] val;

		for (int c = 0; c < NCH; c++) begin
			cur_lvl[c] = '0;
			tgt_lvl[c] = '0;
			ramp_inc[c] = '0;
			is_settled[c] = 1'b1;
			settle_due[c] = 1'b0;
		end
		hold_bits = '0;

		// state right after reset: zero increments, nothing held
		dir_rows.push_back(typed_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000, 1'b0, '0));
		dir_rows.push_back(typed_row(hrsl_pkg::OP_LOAD, 2'd0, 16'h0000, 1'b0, '0));
		dir_rows.push_back(typed_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000, 1'b1,
			dac_res(2'd0, 16'h0000, 1'b1, 1'b1, 1'b1)));
		dir_rows.push_back(typed_row(hrsl_pkg::OP_LOAD, 2'd1, 16'hFFFF, 1'b0, '0));
		dir_rows.push_back(typed_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000, 1'b1,
			dac_res(2'd1, 16'h0000, 1'b1, 1'b0, 1'b1)));
		// full-scale, exact, zero and one-count steps, hold on odd channels
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_INC_CH0, 16'hFFFF));
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_INC_CH1, 16'd12500));
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_INC_CH2, 16'd12));
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_INC_CH3, 16'd13));
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_HOLD, 16'h000A));
		dir_rows.push_back(reg_row(CFG_IDX_TOP, 16'hFFFF));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd0, 16'hFFFF));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd2, 16'h8000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd3, 16'h0001));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		// ramp down, snap with hold, then the delayed settle
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd1, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd2, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		// hold on all, load during a pending settle restarts the ramp
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_HOLD, 16'h000F));
		dir_rows.push_back(reg_row(hrsl_pkg::CFG_INC_CH2, 16'hFFFF));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd2, 16'h0010));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd2, 16'h0020));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));
		dir_rows.push_back(item_row(hrsl_pkg::OP_LOAD, 2'd3, 16'hFFFF));
		dir_rows.push_back(item_row(hrsl_pkg::OP_TICK, 2'd0, 16'h0000));

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		gap_pct = 18;
		stall_pct = 88;
		in_cfg = 1'b0;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_REG) begin
				if (!in_cfg)
					drain();
				write_reg(row.idx, row.val);
				in_cfg = 1'b1;
			end else begin
				if (in_cfg)
					cfg_valid <= 1'b0;
				in_cfg = 1'b0;
				n_before = dac_writes_due.size();
				advance_ramps(row.op, row.ch, row.val);
				if (row.typed) begin
					while (dac_writes_due.size() > n_before)
						dac_writes_due.delete(dac_writes_due.size() - 1);
					if (row.has_res)
						dac_writes_due.push_back(row.res);
				end
				send_item(row.op, row.ch, row.val);
			end
		end

		// random phases with different idling and register settings
		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin
					gap_pct = 18;
					stall_pct = 88;
					program_regs(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom),
						LVL_W'($urandom), HOLD_W'($urandom));
				end
				1: begin
					gap_pct = 88;
					stall_pct = 18;
					program_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 4'hF);
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
					program_regs(LVL_W'($urandom), LVL_W'($urandom_range(1000, 65535)),
						LVL_W'($urandom_range(0, 200)), LVL_W'($urandom), 4'h0);
				end
			endcase
			for (int i = 0; i < ITEMS_PER_MODE; i++) begin
				op = hrsl_pkg::OP_TICK;
				ch = CH_W'($urandom_range(NCH - 1));
				val = LVL_W'($urandom);
				if ($urandom_range(99) < 35) begin
					op = hrsl_pkg::OP_LOAD;
					stp = slew_step(ch);
					case ($urandom_range(3))
						// targets near the current level reach snap and settle
						0, 1: val = cur_lvl[ch] + LVL_W'($urandom_range(0, 2 * stp + 16))
							- LVL_W'(stp + 8);
						2: val = LVL_W'($urandom);
						default: val = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					endcase
				end
				advance_ramps(op, ch, val);
				send_item(op, ch, val);
				if ($urandom_range(99) < 3)
					wait_results();
			end
		end

		drain();
		if (err_cnt == 0)
			$display("[hv_ramp_slew_limiter] OK");
		else
			$display("[hv_ramp_slew_limiter] ERROR");
		$finish;
	end

endmodule
